// ===== rtl/swb_pkg.sv =====
// ----------------------------------------------------------------------------
// swb_pkg: shared types and constants of the swung beat light sweep
// Sequencer states, fixed formats and the elaboration-time table builders.
// ----------------------------------------------------------------------------
package swb_pkg;

   localparam int LAMP_COUNT        = 5;
   localparam int PWM_RANGE_DEF     = 255;
   localparam int PULSE_DEPTH_DEF   = 1024;
   localparam int LIGHT_W           = 8;
   localparam int RSP_W             = LAMP_COUNT * LIGHT_W;
   localparam int LAMP_W            = $clog2(LAMP_COUNT);
   localparam logic [31:0] STEP_RESET = 32'd281474977;
   localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam int PULSE_POWER       = 251;

   localparam logic [7:0] CSR_PHASE_STEP   = 8'd0;
   localparam logic [7:0] CSR_SWING_AMOUNT = 8'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PH_MUL,
      ST_PH_ADD,
      ST_SW_CHECK,
      ST_SW_SEL,
      ST_LG_MUL,
      ST_LG_USE,
      ST_L2_MUL,
      ST_L2_USE,
      ST_EX_MUL,
      ST_EX_USE,
      ST_PW_SHIFT,
      ST_S_SET,
      ST_LT_MUL,
      ST_LT_ROM,
      ST_LT_USE
   } state_type;

   typedef logic [30:0] exp_tbl_type [16];

   function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
      logic [63:0] n;
      logic [63:0] res;
      logic [63:0] bitv;
      n    = n_in;
      res  = 64'd0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 64'd0) begin
         if (n >= res + bitv) begin
            n   = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // C[m] is about 2^(-2^-(m+1)) in Q30
   function automatic exp_tbl_type exp_table();
      exp_tbl_type t;
      logic [63:0] c;
      c = isqrt64(64'd1 << 59);
      t[0] = c[30:0];
      for (int m = 1; m < 16; m++) begin
         c = isqrt64(c << 30);
         t[m] = c[30:0];
      end
      return t;
   endfunction

   function automatic logic [16:0] lamp_pos(input int i);
      longint p;
      p = (longint'(i) * 65536) / (LAMP_COUNT - 1);
      return p[16:0];
   endfunction

   // cos(theta)^251 * range, truncated and saturated
   function automatic logic [7:0] pulse_from_theta(input logic [63:0] theta,
                                                  input logic [63:0] range);
      logic [63:0] t2;
      logic [63:0] h;
      logic [63:0] term;
      logic [63:0] res;
      logic [63:0] base;
      logic [63:0] val;
      int e;
      t2 = (theta * theta) >> 30;
      h  = ONE_Q30;
      for (int m = 0; m < 6; m++) begin
         term = (t2 * h) >> 30;
         case (m)
            0:       term = term / 132;
            1:       term = term / 90;
            2:       term = term / 56;
            3:       term = term / 30;
            4:       term = term / 12;
            default: term = term / 2;
         endcase
         h = (term >= ONE_Q30) ? 64'd0 : ONE_Q30 - term;
      end
      res  = ONE_Q30;
      base = h;
      e    = PULSE_POWER;
      while (e != 0) begin
         if (e % 2 == 1) res = (res * base) >> 30;
         base = (base * base) >> 30;
         e = e / 2;
      end
      val = (res * range) >> 30;
      return (val > 64'd255) ? 8'd255 : val[7:0];
   endfunction

endpackage

// ===== rtl/swb_mul_unit.sv =====
// ----------------------------------------------------------------------------
// swb_mul_unit: shared multiplier
// 32 by 32 unsigned multiply with a registered 64-bit product.
// ----------------------------------------------------------------------------
module swb_mul_unit import swb_pkg::*; (
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [63:0] prod
);

   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   assign prod_in = {32'd0, op_a} * {32'd0, op_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/swb_pulse_rom.sv =====
// ----------------------------------------------------------------------------
// swb_pulse_rom: pulse intensity ROM
// cos(d*pi/2)^251 scaled to the PWM range, one entry per table step, read
// with a registered output.
// ----------------------------------------------------------------------------
module swb_pulse_rom import swb_pkg::*; #(
   parameter int PWM_RANGE         = PWM_RANGE_DEF,
   parameter int PULSE_TABLE_DEPTH = PULSE_DEPTH_DEF,
   parameter int ADDR_W            = $clog2(PULSE_TABLE_DEPTH)
) (
   input  logic              clock,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] rom_tbl [PULSE_TABLE_DEPTH];
   logic [7:0] rd_data_ff;

   for (genvar g = 0; g < PULSE_TABLE_DEPTH; g++) begin : g_entry
      localparam logic [63:0] THETA =
         (64'(g) * HALF_PI_Q30) / PULSE_TABLE_DEPTH;
      assign rom_tbl[g] = pulse_from_theta(THETA, 64'(PWM_RANGE));
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= rom_tbl[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/swung_beat_light_sweep.sv =====
// ----------------------------------------------------------------------------
// swung_beat_light_sweep: metronome light sweep with swing
// Phase accumulator, swing curve and five pulse lights on one multiplier.
// ----------------------------------------------------------------------------
// Each req item (elapsed microseconds) advances a 48-bit beat phase and
// yields one rsp item holding five 8-bit light intensities. All arithmetic
// runs on one registered 32x32 multiplier under a sequencer. After acceptance
// the phase step product is added to the phase and folded; with swing, the
// log2 (16 squarings) is scaled by the swing amount and, unless the swing
// power underflows, fed to the exp2 (16 steps); with no swing or at the curve
// ends both are skipped. Each light then takes an index product and a pulse
// ROM read. req_tready is high only while idle, so the next item is taken
// only after the sequencer returns to idle; while the output register is
// still full, the last light's ROM read is held until it frees, and a
// finished item waits in the output register while the next one is taken.
// Configuration writes (index 0 phase_step, 1 swing_amount) are taken at once.
module swung_beat_light_sweep import swb_pkg::*; #(
   parameter int PWM_RANGE         = PWM_RANGE_DEF,
   parameter int PULSE_TABLE_DEPTH = PULSE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [15:0]       req_tdata,   // [15:0] elapsed_us
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // [7:0] light_zero, [15:8] light_one, [23:16] light_two,
   // [31:24] light_three, [39:32] light_four
   output logic [RSP_W-1:0]  rsp_tdata,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_index,
   input  logic [31:0]       csr_data
);

   localparam int ADDR_W = $clog2(PULSE_TABLE_DEPTH);
   localparam int IDX_W  = $clog2(PULSE_TABLE_DEPTH + 1);
   localparam exp_tbl_type EXP_C = exp_table();
   localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(PULSE_TABLE_DEPTH);

   state_type   state_ff, state_in;
   logic [47:0] phase_ff, phase_in;
   logic [31:0] step_ff, step_in;
   logic [9:0]  swing_ff, swing_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [16:0] v_ff, v_in;
   logic        hi_ff, hi_in;
   logic [3:0]  k_ff, k_in;
   logic [15:0] z_ff, z_in;
   logic [15:0] frac_ff, frac_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [4:0]  n_ff, n_in;
   logic [15:0] f_ff, f_in;
   logic [30:0] r_ff, r_in;
   logic [16:0] pw_ff, pw_in;
   logic [16:0] s_ff, s_in;
   logic [LAMP_W-1:0] lamp_ff, lamp_in;
   logic        oob_ff, oob_in;
   logic [7:0]  light_ff [LAMP_COUNT];
   logic [7:0]  light_in [LAMP_COUNT];
   logic        rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic [31:0] op_a, op_b;
   logic [63:0] prod;
   logic [7:0]  rom_q;
   logic [ADDR_W-1:0] rom_addr;

   logic        req_fire, out_free, last_lamp;
   logic [17:0] x_w, v_w;
   logic [15:0] u_w;
   logic [3:0]  k_w;
   logic [16:0] t_w;
   logic [20:0] l_w;
   logic [23:0] l2_w;
   logic [16:0] d_w, pos_w;
   logic [IDX_W-1:0] idx_w;
   logic [30:0] r_sh_w;

   swb_mul_unit u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   swb_pulse_rom #(
      .PWM_RANGE         (PWM_RANGE),
      .PULSE_TABLE_DEPTH (PULSE_TABLE_DEPTH),
      .ADDR_W            (ADDR_W)
   ) u_rom (
      .clock   (clock),
      .rd_addr (rom_addr),
      .rd_data (rom_q)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_lamp  = (lamp_ff == LAMP_W'(LAMP_COUNT - 1));
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // fold the phase into the triangle and the mirrored curve input
   always_comb begin
      u_w = phase_ff[47:32];
      x_w = (u_w <= 16'd32768) ? {1'b0, u_w, 1'b0} : 18'd131072 - {1'b0, u_w, 1'b0};
      if (x_w >= 18'd32768) v_w = {x_w[16:0], 1'b0} - 18'd65536;
      else                  v_w = 18'd65536 - {x_w[16:0], 1'b0};
      k_w = 4'd0;
      for (int b = 0; b < 16; b++) begin
         if (v_ff[b]) k_w = 4'(b);
      end
      t_w    = prod[31:15];
      l_w    = 21'd1048576 - {1'b0, k_ff, frac_ff};
      l2_w   = prod[31:8];
      r_sh_w = r_ff >> (5'd14 + n_ff);
      pos_w  = lamp_pos(int'(lamp_ff));
      d_w    = (s_ff >= pos_w) ? s_ff - pos_w : pos_w - s_ff;
      idx_w  = prod[16 +: IDX_W];
      rom_addr = idx_w[ADDR_W-1:0];
   end

   // multiplier operands
   always_comb begin
      op_a = 32'd0;
      op_b = 32'd0;
      case (state_ff)
         ST_PH_MUL: begin
            op_a = step_ff;
            op_b = {16'd0, elapsed_ff};
         end
         ST_LG_MUL: begin
            op_a = {16'd0, z_ff};
            op_b = {16'd0, z_ff};
         end
         ST_L2_MUL: begin
            op_a = {11'd0, l_w};
            op_b = {22'd0, 10'd0} + 32'd256 + {22'd0, swing_ff};
         end
         ST_EX_MUL: begin
            op_a = {1'b0, r_ff};
            op_b = {1'b0, EXP_C[cnt_ff]};
         end
         // keep the index product steady while the ROM read is held
         ST_LT_MUL, ST_LT_ROM: begin
            op_a = {15'd0, d_w};
            op_b = 32'(PULSE_TABLE_DEPTH);
         end
         default: begin
            op_a = 32'd0;
            op_b = 32'd0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_fire) state_in = ST_PH_MUL;
         ST_PH_MUL:   state_in = ST_PH_ADD;
         ST_PH_ADD:   state_in = ST_SW_CHECK;
         ST_SW_CHECK: state_in = ST_SW_SEL;
         ST_SW_SEL: begin
            if (v_ff == 17'd0 || v_ff[16] || swing_ff == 10'd0) state_in = ST_S_SET;
            else state_in = ST_LG_MUL;
         end
         ST_LG_MUL:   state_in = ST_LG_USE;
         ST_LG_USE:   state_in = (cnt_ff == 4'd15) ? ST_L2_MUL : ST_LG_MUL;
         ST_L2_MUL:   state_in = ST_L2_USE;
         ST_L2_USE:   state_in = (l2_w[23:16] >= 8'd17) ? ST_S_SET : ST_EX_MUL;
         ST_EX_MUL:   state_in = ST_EX_USE;
         ST_EX_USE:   state_in = (cnt_ff == 4'd15) ? ST_PW_SHIFT : ST_EX_MUL;
         ST_PW_SHIFT: state_in = ST_S_SET;
         ST_S_SET:    state_in = ST_LT_MUL;
         ST_LT_MUL:   state_in = ST_LT_ROM;
         ST_LT_ROM: begin
            // hold the last read until the output register frees
            if (!(last_lamp && !out_free)) state_in = ST_LT_USE;
         end
         ST_LT_USE: begin
            if (!last_lamp)    state_in = ST_LT_MUL;
            else if (out_free) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath register updates
   always_comb begin
      phase_in     = phase_ff;
      step_in      = step_ff;
      swing_in     = swing_ff;
      elapsed_in   = elapsed_ff;
      v_in         = v_ff;
      hi_in        = hi_ff;
      k_in         = k_ff;
      z_in         = z_ff;
      frac_in      = frac_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      f_in         = f_ff;
      r_in         = r_ff;
      pw_in        = pw_ff;
      s_in         = s_ff;
      lamp_in      = lamp_ff;
      oob_in       = oob_ff;
      light_in     = light_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PHASE_STEP:   step_in  = csr_data;
            CSR_SWING_AMOUNT: swing_in = csr_data[9:0];
            default:          ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) elapsed_in = req_tdata;
         end
         ST_PH_ADD: phase_in = phase_ff + prod[47:0];
         ST_SW_CHECK: begin
            v_in  = v_w[16:0];
            hi_in = (x_w >= 18'd32768);
         end
         ST_SW_SEL: begin
            // curve ends and no swing bypass the log/exp path
            if (v_ff == 17'd0)          pw_in = 17'd0;
            else if (v_ff[16])          pw_in = 17'd65536;
            else                        pw_in = v_ff;
            k_in    = k_w;
            z_in    = v_ff[15:0] << (4'd15 - k_w);
            frac_in = 16'd0;
            cnt_in  = 4'd0;
         end
         ST_LG_USE: begin
            frac_in = {frac_ff[14:0], t_w[16]};
            z_in    = t_w[16] ? t_w[16:1] : t_w[15:0];
            cnt_in  = cnt_ff + 4'd1;
         end
         ST_L2_USE: begin
            n_in   = l2_w[20:16];
            f_in   = l2_w[15:0];
            r_in   = 31'h4000_0000;
            cnt_in = 4'd0;
            if (l2_w[23:16] >= 8'd17) pw_in = 17'd0;
         end
         ST_EX_USE: begin
            if (f_ff[~cnt_ff]) r_in = prod[60:30];
            cnt_in = cnt_ff + 4'd1;
         end
         ST_PW_SHIFT: pw_in = r_sh_w[16:0];
         ST_S_SET: begin
            s_in    = hi_ff ? 17'd32768 + {1'b0, pw_ff[16:1]}
                            : 17'd32768 - {1'b0, pw_ff[16:1]};
            lamp_in = '0;
         end
         ST_LT_ROM: oob_in = (idx_w >= DEPTH_IDX);
         ST_LT_USE: begin
            light_in[lamp_ff] = oob_ff ? 8'd0 : rom_q;
            if (!last_lamp) begin
               lamp_in = lamp_ff + LAMP_W'(1);
            end else if (out_free) begin
               // hold the finished item until the output register frees
               rsp_valid_in = 1'b1;
               for (int i = 0; i < LAMP_COUNT - 1; i++) begin
                  rsp_data_in[i*LIGHT_W +: LIGHT_W] = light_ff[i];
               end
               rsp_data_in[(LAMP_COUNT-1)*LIGHT_W +: LIGHT_W] = oob_ff ? 8'd0 : rom_q;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 48'd0;
         step_ff      <= STEP_RESET;
         swing_ff     <= 10'd0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= 4'd0;
         lamp_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         swing_ff     <= swing_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         lamp_ff      <= lamp_in;
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff  <= elapsed_in;
      v_ff        <= v_in;
      hi_ff       <= hi_in;
      k_ff        <= k_in;
      z_ff        <= z_in;
      frac_ff     <= frac_in;
      n_ff        <= n_in;
      f_ff        <= f_in;
      r_ff        <= r_in;
      pw_ff       <= pw_in;
      s_ff        <= s_in;
      oob_ff      <= oob_in;
      light_ff    <= light_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_PH_MUL)
      else $error("accepted item did not start the phase multiply");

   a_finish_loads : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LT_USE && last_lamp && out_free) |=> rsp_valid_ff)
      else $error("finished item not loaded into the output register");

   a_lamp_range : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LT_USE |-> lamp_ff <= LAMP_W'(LAMP_COUNT - 1))
      else $error("light index out of range");

   a_idle_ready : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LT_ROM && last_lamp && !out_free) |=> state_ff == ST_LT_ROM)
      else $error("finished item dropped while output busy");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the swung beat light sweep
// Drives elapsed-time items with random gaps and backpressure, models the
// phase accumulator, swing curve and pulse lights, and checks every result.
// ----------------------------------------------------------------------------

class beat_scoreboard;
   logic [47:0] beat_phase;
   logic [31:0] phase_step;
   logic [9:0]  swing_amount;
   logic [63:0] root_tbl [16];
   logic [39:0] expected_lights [$];
   int          errors;

   function new();
      logic [63:0] c;
      c = int_sqrt(64'd1 << 59);
      root_tbl[0] = c;
      for (int m = 1; m < 16; m++) begin
         c = int_sqrt(c << 30);
         root_tbl[m] = c;
      end
      beat_phase   = '0;
      phase_step   = swb_pkg::STEP_RESET;
      swing_amount = '0;
      errors       = 0;
   endfunction

   // floor square root, one result bit at a time
   function logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= n) r = t;
      end
      return r;
   endfunction

   function void write_reg(input logic [7:0] index, input logic [31:0] value);
      if (index == swb_pkg::CSR_PHASE_STEP) phase_step = value;
      else if (index == swb_pkg::CSR_SWING_AMOUNT) swing_amount = value[9:0];
   endfunction

   function logic [31:0] log2_fix(input logic [31:0] v);
      int          k;
      logic [63:0] z;
      logic [15:0] frac;
      k = 15;
      while (k > 0 && v[k] == 1'b0) k--;
      z = 64'(v) << (15 - k);
      frac = '0;
      for (int i = 0; i < 16; i++) begin
         z = (z * z) >> 15;
         frac = frac << 1;
         if (z >= 64'd65536) begin
            frac[0] = 1'b1;
            z = z >> 1;
         end
      end
      return (32'(k) << 16) | 32'(frac);
   endfunction

   function logic [31:0] swing_curve(input logic [31:0] v);
      logic [63:0] l;
      logic [63:0] l2;
      logic [63:0] r;
      logic [31:0] n;
      logic [15:0] f;
      if (v == 0) return 0;
      if (v >= 32'd65536) return 32'd65536;
      if (swing_amount == 0) return v;
      l  = (64'd16 << 16) - 64'(log2_fix(v));
      l2 = (l * (64'd256 + 64'(swing_amount))) >> 8;
      n  = 32'(l2 >> 16);
      f  = l2[15:0];
      if (n >= 17) return 0;
      r = 64'd1 << 30;
      for (int j = 15; j >= 0; j--)
         if (f[j]) r = (r * root_tbl[15 - j]) >> 30;
      return 32'(r >> (14 + n));
   endfunction

   function logic [7:0] pulse_level(input logic [31:0] idx);
      logic [63:0] theta, t2, h, term, acc, base, val;
      int          divs [6];
      int          e;
      divs = '{132, 90, 56, 30, 12, 2};
      if (idx >= 1024) return 0;
      theta = (64'(idx) * 64'd1686629713) / 1024;
      t2 = (theta * theta) >> 30;
      h = 64'd1 << 30;
      for (int m = 0; m < 6; m++) begin
         term = ((t2 * h) >> 30) / divs[m];
         h = (term >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - term;
      end
      acc = 64'd1 << 30;
      base = h;
      for (e = 251; e != 0; e = e >> 1) begin
         if (e & 1) acc = (acc * base) >> 30;
         base = (base * base) >> 30;
      end
      val = (acc * 64'd255) >> 30;
      return (val > 255) ? 8'd255 : val[7:0];
   endfunction

   function void note_elapsed(input logic [15:0] elapsed);
      logic [31:0] u, x, v, s, pos, d;
      logic [39:0] lights;
      beat_phase = beat_phase + 48'(64'(elapsed) * 64'(phase_step));
      u = 32'(beat_phase[47:32]);
      x = (u <= 32768) ? 2 * u : 131072 - 2 * u;
      if (x >= 32768) begin
         v = 2 * x - 65536;
         s = 32768 + (swing_curve(v) >> 1);
      end else begin
         v = 65536 - 2 * x;
         s = 32768 - (swing_curve(v) >> 1);
      end
      for (int i = 0; i < 5; i++) begin
         pos = (i * 65536) / 4;
         d = (s >= pos) ? s - pos : pos - s;
         lights[8*i +: 8] = pulse_level(32'((64'(d) * 1024) >> 16));
      end
      expected_lights.push_back(lights);
   endfunction

   function void check_lights(input logic [39:0] got);
      logic [39:0] want;
      if (expected_lights.size() == 0) begin
         $display("%0t: unexpected result %h", $time, got);
         errors++;
         return;
      end
      want = expected_lights.pop_front();
      for (int i = 0; i < 5; i++)
         if (want[8*i +: 8] !== got[8*i +: 8]) begin
            $display("%0t: light %0d expected %0d actual %0d", $time, i,
                     want[8*i +: 8], got[8*i +: 8]);
            errors++;
         end
   endfunction
endclass

module tb_top;
   import swb_pkg::*;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_tvalid = 0;
   logic              req_tready;
   logic [15:0]       req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_valid = 0;
   logic              csr_ready;
   logic [7:0]        csr_index = '0;
   logic [31:0]       csr_data = '0;

   beat_scoreboard sweep_model = new();
   bit             no_gaps = 0;
   int             quiet_cycles = 0;

   localparam int WATCHDOG_LIMIT = 5000;

   swung_beat_light_sweep dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("swung_beat_light_sweep regression: fail");
         $finish;
      end
   end

   task automatic send_elapsed(input logic [15:0] elapsed);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= elapsed;
      do @(posedge clock); while (!req_tready);
      sweep_model.note_elapsed(elapsed);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sweep_model.expected_lights.size() != 0);
      // the sequencer may still be finishing; give it a full item time
      repeat (150) @(posedge clock);
   endtask

   task automatic write_csr(input logic [7:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sweep_model.write_reg(index, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // result side: random backpressure, check each accepted item
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = no_gaps ? 0 : $urandom_range(0, 6);
         repeat (gap) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sweep_model.check_lights(rsp_tdata);
      end
   end

   initial begin
      logic [31:0] steps [6];
      logic [31:0] swings [6];
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: extremes and alternating patterns of the elapsed field
      send_elapsed(16'd0);
      send_elapsed(16'hFFFF);
      send_elapsed(16'd1);
      send_elapsed(16'h5555);
      send_elapsed(16'hAAAA);
      drain();

      // land exactly on the curve middle and ends, with full swing
      write_csr(CSR_PHASE_STEP, 32'h8000_0000);
      write_csr(CSR_SWING_AMOUNT, 32'd1023);
      repeat (8) send_elapsed(16'd32768);
      send_elapsed(16'd16384);
      repeat (4) send_elapsed(16'd32768);
      send_elapsed(16'hFFFF);
      drain();

      steps  = '{32'd0, 32'hFFFF_FFFF, STEP_RESET, $urandom, 32'd1 + $urandom_range(0, 4096),
                 $urandom};
      swings = '{32'd1023, 32'd0, $urandom, 32'hFFFF_FC00 | $urandom_range(0, 1023),
                 32'd1, $urandom};
      for (int p = 0; p < 6; p++) begin
         write_csr(CSR_PHASE_STEP, steps[p]);
         write_csr(CSR_SWING_AMOUNT, swings[p]);
         // unknown index must leave both registers alone
         write_csr(8'($urandom_range(2, 255)), $urandom);
         no_gaps = (p == 2);
         send_elapsed(16'hFFFF);
         send_elapsed(16'd0);
         for (int n = 0; n < 180; n++) begin
            if (p == 3 && n == 90) drain();
            case ($urandom_range(0, 3))
               0:       send_elapsed(16'($urandom_range(0, 255)));
               default: send_elapsed(16'($urandom));
            endcase
         end
         drain();
      end
      no_gaps = 0;

      if (sweep_model.errors == 0 && sweep_model.expected_lights.size() == 0)
         $display("swung_beat_light_sweep regression: pass");
      else
         $display("swung_beat_light_sweep regression: fail");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/swb_pkg.sv
rtl/swb_mul_unit.sv
rtl/swb_pulse_rom.sv
rtl/swung_beat_light_sweep.sv
tb/tb_top.sv
